// ===== hdl/pvaos_pkg.sv =====
`timescale 1ns / 1ps
package pvaos_pkg;

  localparam int VOICE_CNT_DEF = 8;
  localparam int VEL_W         = 7;
  localparam int PITCH_W       = 7;
  localparam int VOICE_W       = 3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CHOOSE,
    ST_AGE_SEARCH,
    ST_AGE_SHIFT,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic clear;
    logic search;
    logic shift;
  } age_ctrl_t;

endpackage

// ===== hdl/pvaos_age_list.sv =====
`timescale 1ns / 1ps
module pvaos_age_list #(
  parameter int VOICE_CNT = pvaos_pkg::VOICE_CNT_DEF,
  localparam int VW = $clog2(VOICE_CNT)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  pvaos_pkg::age_ctrl_t  ctrl,
  input  logic [VW-1:0]         idx,
  input  logic [VW-1:0]         voice,
  output logic                  oldest_vld,
  output logic [VW-1:0]         oldest_idx
);
  import pvaos_pkg::*;

  // Entries are ordered oldest first; an entry without its valid bit is empty.
  logic [VOICE_CNT-1:0] vld_r;
  logic [VW-1:0]        idx_r [VOICE_CNT];
  logic                 found_r;
  logic [VW-1:0]        start_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else if (ctrl.clear) begin
      found_r <= 1'b0;
    end else if (ctrl.search && !found_r && vld_r[idx] && idx_r[idx] == voice) begin
      found_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      start_r <= '0;
    end else if (ctrl.search && !found_r && vld_r[idx] && idx_r[idx] == voice) begin
      start_r <= idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (ctrl.shift) begin
      for (int j = 0; j < VOICE_CNT - 1; j++) begin
        if (j >= int'(start_r)) begin
          vld_r[j] <= vld_r[j+1];
        end
      end
      vld_r[VOICE_CNT-1] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      for (int j = 0; j < VOICE_CNT - 1; j++) begin
        if (j >= int'(start_r)) begin
          idx_r[j] <= idx_r[j+1];
        end
      end
      idx_r[VOICE_CNT-1] <= voice;
    end
  end

  assign oldest_vld = vld_r[0];
  assign oldest_idx = idx_r[0];

endmodule

// ===== hdl/poly_voice_allocator_oldest_steal_top.sv =====
`timescale 1ns / 1ps
// Channel   Ports                                              Direction
// input     in_valid, in_stall, in_velocity, in_pitch          in (stall out)
// result    out_valid, out_stall, out_voice, out_is_note_on,   out (stall in)
//           out_stolen, out_error
//
// A single comparator walks the voice table one voice per cycle, and on a note on
// it walks the age list once more before shifting it.
// Reset is synchronous; all voices come up free and the age list comes up empty.
// A new transaction is taken while the previous result still waits in the output
// register; a stalled output only holds the block in its final state.
module poly_voice_allocator_oldest_steal_top #(
  parameter int VOICE_CNT = pvaos_pkg::VOICE_CNT_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [pvaos_pkg::VEL_W-1:0]     in_velocity,
  input  logic [pvaos_pkg::PITCH_W-1:0]   in_pitch,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [pvaos_pkg::VOICE_W-1:0]   out_voice,
  output logic                            out_is_note_on,
  output logic                            out_stolen,
  output logic                            out_error
);
  import pvaos_pkg::*;

  localparam int VW = $clog2(VOICE_CNT);

  state_t              state_r, state_nxt;
  logic [VW-1:0]       cnt_r;
  logic                last;
  logic [VEL_W-1:0]    vel_r;
  logic [PITCH_W-1:0]  pit_r;
  logic                note_on;
  logic                found_r;
  logic [VW-1:0]       sel_r;
  logic                stolen_r;
  logic [VW-1:0]       chosen;

  logic [PITCH_W-1:0]   pitch_r [VOICE_CNT];
  logic [VOICE_CNT-1:0] pset_r;
  logic [VOICE_CNT-1:0] busy_r;

  logic                out_valid_r;
  logic [VOICE_W-1:0]  out_voice_r;
  logic                out_is_note_on_r;
  logic                out_stolen_r;
  logic                out_error_r;

  age_ctrl_t           age_ctrl;
  logic                oldest_vld;
  logic [VW-1:0]       oldest_idx;
  logic                accept;
  logic                out_free;
  logic                hit;

  assign note_on  = (vel_r != '0);
  assign last     = (cnt_r == VW'(VOICE_CNT - 1));
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign hit      = pset_r[cnt_r] && (pitch_r[cnt_r] == pit_r);
  assign chosen   = found_r ? sel_r : (oldest_vld ? oldest_idx : '0);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:       if (in_valid) state_nxt = ST_SCAN;
      ST_SCAN:       if (last) state_nxt = note_on ? ST_CHOOSE : ST_RESULT;
      ST_CHOOSE:     state_nxt = ST_AGE_SEARCH;
      ST_AGE_SEARCH: if (last) state_nxt = ST_AGE_SHIFT;
      ST_AGE_SHIFT:  state_nxt = ST_RESULT;
      ST_RESULT:     if (out_free) state_nxt = ST_IDLE;
      default:       state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall        = 1'b1;
    age_ctrl.clear  = 1'b0;
    age_ctrl.search = 1'b0;
    age_ctrl.shift  = 1'b0;
    unique case (state_r)
      ST_IDLE:       in_stall = 1'b0;
      ST_CHOOSE:     age_ctrl.clear = 1'b1;
      ST_AGE_SEARCH: age_ctrl.search = 1'b1;
      ST_AGE_SHIFT:  age_ctrl.shift = 1'b1;
      default:       in_stall = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      found_r <= 1'b0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          cnt_r   <= '0;
          found_r <= 1'b0;
        end
        ST_SCAN: begin
          cnt_r <= last ? '0 : cnt_r + 1'b1;
          if (note_on ? (!busy_r[cnt_r] && !found_r) : hit) begin
            found_r <= 1'b1;
          end
        end
        ST_AGE_SEARCH: cnt_r <= last ? '0 : cnt_r + 1'b1;
        default: cnt_r <= '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      vel_r <= in_velocity;
      pit_r <= in_pitch;
    end
    if (state_r == ST_SCAN && (note_on ? (!busy_r[cnt_r] && !found_r) : hit)) begin
      sel_r <= cnt_r;
    end else if (state_r == ST_CHOOSE) begin
      sel_r    <= chosen;
      stolen_r <= !found_r;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_CHOOSE) begin
      pitch_r[chosen] <= pit_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pset_r <= '0;
      busy_r <= '0;
    end else if (state_r == ST_SCAN && !note_on && hit) begin
      busy_r[cnt_r] <= 1'b0;
    end else if (state_r == ST_CHOOSE) begin
      busy_r[chosen] <= 1'b1;
      pset_r[chosen] <= 1'b1;
    end
  end

  pvaos_age_list #(
    .VOICE_CNT(VOICE_CNT)
  ) u_age_list (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (age_ctrl),
    .idx       (cnt_r),
    .voice     (sel_r),
    .oldest_vld(oldest_vld),
    .oldest_idx(oldest_idx)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_RESULT && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_RESULT && out_free) begin
      out_is_note_on_r <= note_on;
      if (note_on) begin
        out_voice_r  <= VOICE_W'(sel_r);
        out_stolen_r <= stolen_r;
        out_error_r  <= 1'b0;
      end else begin
        out_voice_r  <= found_r ? VOICE_W'(sel_r) : '0;
        out_stolen_r <= 1'b0;
        out_error_r  <= !found_r;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_voice      = out_voice_r;
  assign out_is_note_on = out_is_note_on_r;
  assign out_stolen     = out_stolen_r;
  assign out_error      = out_error_r;

endmodule
